// ----- sv/brcc_pkg.sv -----
// Package of the balance robot cascade controller: widths, reset values,
// register and sequencer codes, line-sensor tables and saturation helpers.
// Used by brcc_mul and balance_robot_cascade_controller; depends on nothing.
package brcc_pkg;

	localparam int GAIN_W     = 32;
	localparam int BAL_W      = 17;
	localparam int OPB_W      = 25;
	localparam int PROD_W     = GAIN_W + OPB_W;
	localparam int ACC_W      = 58;
	localparam int TGT_W      = 8;
	localparam int FILT_W     = 18;
	localparam int INTEG_W    = 15;
	localparam int VAL_W      = 16;
	localparam int NUM_W      = 22;
	localparam int QUO_W      = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 80;

	localparam int SPEED_LIMIT_DEF = 20;
	localparam int TURN_LIMIT_DEF  = 100;
	localparam int INTEG_LIMIT     = 10000;
	localparam int NEAR_RANGE      = 50;
	localparam int TURN_STEP       = 30;

	// Reciprocal of ten, scaled by 2^24 and rounded up; exact for magnitudes below 2^22.
	localparam logic signed [GAIN_W-1:0] RECIP10 = 32'sd1677722;
	localparam int DIV10_SHIFT = 24;
	localparam int SPEED_SHIFT = 16;
	localparam int UPR_SHIFT   = 24;
	localparam int KD_SHIFT    = 8;

	localparam logic signed [BAL_W-1:0]  BALANCE_ANGLE_RST     = '0;
	localparam logic signed [GAIN_W-1:0] UPRIGHT_KP_RST        = -32'sd26214400;
	localparam logic signed [GAIN_W-1:0] UPRIGHT_KD_RST        = -32'sd125829;
	localparam logic signed [GAIN_W-1:0] SPEED_KP_RST          = -32'sd28836;
	localparam logic signed [GAIN_W-1:0] SPEED_KI_RST          = -32'sd144;
	localparam logic signed [GAIN_W-1:0] YAW_DAMPING_GAIN_RST  = 32'sd39322;
	localparam logic signed [GAIN_W-1:0] TURN_COMMAND_GAIN_RST = 32'sd1310720;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BALANCE_ANGLE     = 3'd0,
		REG_UPRIGHT_KP        = 3'd1,
		REG_UPRIGHT_KD        = 3'd2,
		REG_SPEED_KP          = 3'd3,
		REG_SPEED_KI          = 3'd4,
		REG_YAW_DAMPING_GAIN  = 3'd5,
		REG_TURN_COMMAND_GAIN = 3'd6,
		REG_LINE_FOLLOW       = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CMD,
		S_LS_MUL,
		S_LT_MUL,
		S_LT_FIN,
		S_FILT_MUL,
		S_FILT_FIN,
		S_SPD_M1,
		S_SPD_M2,
		S_SPD_FIN,
		S_TRN_M2,
		S_TRN_FIN,
		S_UPR_M2,
		S_UPR_FIN,
		S_OUT
	} state_t;

	function automatic logic signed [TGT_W-1:0] line_speed_tab(input logic [4:0] pattern);
		logic signed [TGT_W-1:0] v;
		case (pattern)
			5'd27:   v = -8'sd30;
			5'd31:   v = -8'sd2;
			default: v = -8'sd6;
		endcase
		return v;
	endfunction

	function automatic logic signed [TGT_W-1:0] line_turn_tab(input logic [4:0] pattern);
		logic signed [TGT_W-1:0] v;
		case (pattern) inside
			5'd7, 5'd15, 5'd19, 5'd23:  v = -8'sd80;
			5'd25, 5'd28, 5'd29, 5'd30: v = 8'sd80;
			default:                    v = '0;
		endcase
		return v;
	endfunction

	// Arithmetic right shift that truncates toward zero.
	function automatic logic signed [ACC_W-1:0] trunc_shr(input logic signed [ACC_W-1:0] v,
			input int unsigned sh);
		logic signed [ACC_W-1:0] bias;
		bias = v[ACC_W-1] ? ((ACC_W'(1) <<< sh) - ACC_W'(1)) : '0;
		return (v + bias) >>> sh;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v > SAT_MAX) begin
			r = VAL_W'(SAT_MAX);
		end else if (v < SAT_MIN) begin
			r = VAL_W'(SAT_MIN);
		end else begin
			r = VAL_W'(v);
		end
		return r;
	endfunction

endpackage

// ----- sv/brcc_mul.sv -----
// Shared signed multiplier of the controller with a registered product.
// Depends on brcc_pkg for operand widths.
module brcc_mul (
	input  logic                                  clk,
	input  logic signed [brcc_pkg::GAIN_W-1:0]    a,
	input  logic signed [brcc_pkg::OPB_W-1:0]     b,
	output logic signed [brcc_pkg::PROD_W-1:0]    p
);

	logic signed [brcc_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= brcc_pkg::PROD_W'(a) * brcc_pkg::PROD_W'(b);
	end

	assign p = prod_q;

endmodule

// ----- sv/balance_robot_cascade_controller.sv -----
// Top level of the balance robot cascade controller: input capture, sequencer,
// loop state, configuration registers and output register.
// Depends on brcc_pkg and instantiates brcc_mul.
//
// One transfer on the s_ channel is one control tick. Its result leaves as one
// transfer on the m_ channel. The user is to write gains and options on the
// cfg_ port only while the block is idle; the block itself does not enforce it.
// A write takes effect at the next clock edge. s_tready is high only while the
// sequencer is idle. After an accepted transfer the sequencer walks the tick
// through one shared 32 x 25 bit multiplier: the speed error filter divide,
// the two speed loop products, the two turn loop products and the two upright
// loop products, each followed by its accumulate and truncate step. m_tvalid
// rises once the sequencer has passed S_CMD, these steps and S_OUT; in
// line-follow mode the two smoothing divides add three sequencer steps. A new
// tick is accepted only after the last one has left S_OUT. The result waits in
// an output register; a stalled receiver holds the next result in the final
// sequencer step until the register empties. Reset clears the loop state and
// loads the default gains; no result is pending after reset.
module balance_robot_cascade_controller #(
	parameter int SPEED_LIMIT = brcc_pkg::SPEED_LIMIT_DEF,
	parameter int TURN_LIMIT  = brcc_pkg::TURN_LIMIT_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// left_wheel_count[15:0], right_wheel_count[31:16], pitch_angle[48:32],
	// pitch_rate[64:49], yaw_rate[80:65], cmd_forward[81], cmd_backward[82],
	// cmd_left[83], cmd_right[84], obstacle_distance[100:85],
	// line_sensors[105:101], clear_integral[106], zero fill above.
	input  logic [brcc_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// motor_left[15:0], motor_right[31:16], upright_out[47:32],
	// speed_out[63:48], turn_drive[79:64].
	output logic [brcc_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                  cfg_we,
	input  logic [brcc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [brcc_pkg::GAIN_W-1:0]           cfg_data
);

	localparam logic signed [9:0] SPD_LIM = 10'(SPEED_LIMIT);
	localparam logic signed [9:0] TRN_LIM = 10'(TURN_LIMIT);
	localparam logic signed [18:0] INT_LIM = 19'(brcc_pkg::INTEG_LIMIT);

	brcc_pkg::state_t state_q, state_d;

	logic signed [brcc_pkg::BAL_W-1:0]  bal_q;
	logic signed [brcc_pkg::GAIN_W-1:0] upr_kp_q, upr_kd_q, spd_kp_q, spd_ki_q;
	logic signed [brcc_pkg::GAIN_W-1:0] yaw_gain_q, turn_gain_q;
	logic                               lfe_q;

	logic signed [brcc_pkg::VAL_W-1:0]  left_q, right_q, prate_q, yaw_q;
	logic signed [brcc_pkg::BAL_W-1:0]  pitch_q;
	logic                               fwd_q, back_q, lcmd_q, rcmd_q, clr_q;
	logic [brcc_pkg::VAL_W-1:0]         dist_q;
	logic [4:0]                         pattern_q;

	logic signed [brcc_pkg::TGT_W-1:0]   ts_q, tt_q, lss_q, lts_q;
	logic signed [brcc_pkg::FILT_W-1:0]  filt_q;
	logic signed [brcc_pkg::INTEG_W-1:0] integ_q;
	logic signed [brcc_pkg::VAL_W-1:0]   spd_q, trn_q, upr_q;
	logic signed [brcc_pkg::ACC_W-1:0]   acc_q;
	logic                                neg_q;
	logic [brcc_pkg::OUT_TDATA_W-1:0]    m_tdata_q;
	logic                                m_tvalid_q;

	logic                                in_xfer, out_load;
	logic signed [9:0]                   ts_ramp, tt_ramp, ts_cmd, tt_cmd;
	logic signed [11:0]                  ls_num, lt_num;
	logic signed [brcc_pkg::FILT_W-1:0]  err;
	logic signed [brcc_pkg::NUM_W-1:0]   filt_num, div_num, div_mag;
	logic signed [brcc_pkg::QUO_W-1:0]   quo_mag, quo;
	logic signed [18:0]                  integ_sum, integ_new;
	logic signed [brcc_pkg::OPB_W-1:0]   pitch_err;
	logic signed [brcc_pkg::GAIN_W-1:0]  mul_a;
	logic signed [brcc_pkg::OPB_W-1:0]   mul_b;
	logic signed [brcc_pkg::PROD_W-1:0]  prod;
	logic signed [brcc_pkg::ACC_W-1:0]   prod_ext, sum_plain, sum_kd;
	logic signed [brcc_pkg::VAL_W-1:0]   mot_l, mot_r;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_load = (state_q == brcc_pkg::S_OUT) && (!m_tvalid_q || m_tready);

	brcc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			brcc_pkg::S_IDLE:     if (in_xfer) state_d = brcc_pkg::S_CMD;
			brcc_pkg::S_CMD:      state_d = lfe_q ? brcc_pkg::S_LS_MUL : brcc_pkg::S_FILT_MUL;
			brcc_pkg::S_LS_MUL:   state_d = brcc_pkg::S_LT_MUL;
			brcc_pkg::S_LT_MUL:   state_d = brcc_pkg::S_LT_FIN;
			brcc_pkg::S_LT_FIN:   state_d = brcc_pkg::S_FILT_MUL;
			brcc_pkg::S_FILT_MUL: state_d = brcc_pkg::S_FILT_FIN;
			brcc_pkg::S_FILT_FIN: state_d = brcc_pkg::S_SPD_M1;
			brcc_pkg::S_SPD_M1:   state_d = brcc_pkg::S_SPD_M2;
			brcc_pkg::S_SPD_M2:   state_d = brcc_pkg::S_SPD_FIN;
			brcc_pkg::S_SPD_FIN:  state_d = brcc_pkg::S_TRN_M2;
			brcc_pkg::S_TRN_M2:   state_d = brcc_pkg::S_TRN_FIN;
			brcc_pkg::S_TRN_FIN:  state_d = brcc_pkg::S_UPR_M2;
			brcc_pkg::S_UPR_M2:   state_d = brcc_pkg::S_UPR_FIN;
			brcc_pkg::S_UPR_FIN:  state_d = brcc_pkg::S_OUT;
			brcc_pkg::S_OUT:      if (out_load) state_d = brcc_pkg::S_IDLE;
			default:              state_d = brcc_pkg::S_IDLE;
		endcase
	end

	// Multiplier operand selection per sequencer step, and s_tready while idle.
	always_comb begin
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			brcc_pkg::S_IDLE: begin
				s_tready = 1'b1;
			end
			brcc_pkg::S_LS_MUL, brcc_pkg::S_LT_MUL, brcc_pkg::S_FILT_MUL: begin
				mul_a = brcc_pkg::RECIP10;
				mul_b = brcc_pkg::OPB_W'(div_mag);
			end
			brcc_pkg::S_SPD_M1: begin
				mul_a = spd_kp_q;
				mul_b = brcc_pkg::OPB_W'(filt_q);
			end
			brcc_pkg::S_SPD_M2: begin
				mul_a = spd_ki_q;
				mul_b = brcc_pkg::OPB_W'(integ_q);
			end
			brcc_pkg::S_SPD_FIN: begin
				mul_a = yaw_gain_q;
				mul_b = brcc_pkg::OPB_W'(yaw_q);
			end
			brcc_pkg::S_TRN_M2: begin
				mul_a = turn_gain_q;
				mul_b = brcc_pkg::OPB_W'(tt_q);
			end
			brcc_pkg::S_TRN_FIN: begin
				mul_a = upr_kp_q;
				mul_b = pitch_err;
			end
			brcc_pkg::S_UPR_M2: begin
				mul_a = upr_kd_q;
				mul_b = brcc_pkg::OPB_W'(prate_q);
			end
			default: begin
				mul_a = '0;
			end
		endcase
	end

	// Command ramps and clamps.
	always_comb begin
		ts_ramp = (fwd_q || back_q) ? 10'(ts_q) : '0;
		if (fwd_q) begin
			ts_ramp = (dist_q < 16'(brcc_pkg::NEAR_RANGE)) ? ts_ramp + 10'sd1 : ts_ramp - 10'sd1;
		end
		if (back_q) begin
			ts_ramp = ts_ramp + 10'sd1;
		end
		tt_ramp = (lcmd_q || rcmd_q) ? 10'(tt_q) : '0;
		if (lcmd_q) begin
			tt_ramp = tt_ramp + 10'(brcc_pkg::TURN_STEP);
		end
		if (rcmd_q) begin
			tt_ramp = tt_ramp - 10'(brcc_pkg::TURN_STEP);
		end
		ts_cmd = (ts_ramp > SPD_LIM) ? SPD_LIM : ((ts_ramp < -SPD_LIM) ? -SPD_LIM : ts_ramp);
		tt_cmd = (tt_ramp > TRN_LIM) ? TRN_LIM : ((tt_ramp < -TRN_LIM) ? -TRN_LIM : tt_ramp);
	end

	// Divide by ten, filter, integrator, pitch error, sums and motor mix.
	always_comb begin
		ls_num   = (12'(lss_q) <<< 3) + 12'(lss_q) + 12'(brcc_pkg::line_speed_tab(pattern_q));
		lt_num   = (12'(lts_q) <<< 3) + 12'(lts_q) + 12'(brcc_pkg::line_turn_tab(pattern_q));
		err      = brcc_pkg::FILT_W'(left_q) + brcc_pkg::FILT_W'(right_q)
			- brcc_pkg::FILT_W'(ts_q);
		filt_num = (brcc_pkg::NUM_W'(err) <<< 1) + brcc_pkg::NUM_W'(err)
			+ (brcc_pkg::NUM_W'(filt_q) <<< 3) - brcc_pkg::NUM_W'(filt_q);
		case (state_q)
			brcc_pkg::S_LS_MUL: div_num = brcc_pkg::NUM_W'(ls_num);
			brcc_pkg::S_LT_MUL: div_num = brcc_pkg::NUM_W'(lt_num);
			default:            div_num = filt_num;
		endcase
		div_mag   = div_num[brcc_pkg::NUM_W-1] ? -div_num : div_num;
		quo_mag   = brcc_pkg::QUO_W'(prod[brcc_pkg::DIV10_SHIFT +: brcc_pkg::QUO_W - 1]);
		quo       = neg_q ? -quo_mag : quo_mag;
		integ_sum = 19'(integ_q) + 19'(brcc_pkg::FILT_W'(quo));
		if (clr_q) begin
			integ_new = '0;
		end else if (integ_sum > INT_LIM) begin
			integ_new = INT_LIM;
		end else if (integ_sum < -INT_LIM) begin
			integ_new = -INT_LIM;
		end else begin
			integ_new = integ_sum;
		end
		pitch_err = brcc_pkg::OPB_W'(pitch_q)
			- ((brcc_pkg::OPB_W'(spd_q) <<< 8) + brcc_pkg::OPB_W'(bal_q));
		prod_ext  = brcc_pkg::ACC_W'(prod);
		sum_plain = acc_q + prod_ext;
		sum_kd    = acc_q + (prod_ext <<< brcc_pkg::KD_SHIFT);
		mot_l     = brcc_pkg::sat16(brcc_pkg::ACC_W'(upr_q) - brcc_pkg::ACC_W'(trn_q));
		mot_r     = brcc_pkg::sat16(brcc_pkg::ACC_W'(upr_q) + brcc_pkg::ACC_W'(trn_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= brcc_pkg::S_IDLE;
			bal_q       <= brcc_pkg::BALANCE_ANGLE_RST;
			upr_kp_q    <= brcc_pkg::UPRIGHT_KP_RST;
			upr_kd_q    <= brcc_pkg::UPRIGHT_KD_RST;
			spd_kp_q    <= brcc_pkg::SPEED_KP_RST;
			spd_ki_q    <= brcc_pkg::SPEED_KI_RST;
			yaw_gain_q  <= brcc_pkg::YAW_DAMPING_GAIN_RST;
			turn_gain_q <= brcc_pkg::TURN_COMMAND_GAIN_RST;
			lfe_q       <= 1'b0;
			ts_q        <= '0;
			tt_q        <= '0;
			lss_q       <= '0;
			lts_q       <= '0;
			filt_q      <= '0;
			integ_q     <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (brcc_pkg::cfg_reg_t'(cfg_index))
					brcc_pkg::REG_BALANCE_ANGLE:     bal_q <= brcc_pkg::BAL_W'(cfg_data);
					brcc_pkg::REG_UPRIGHT_KP:        upr_kp_q <= cfg_data;
					brcc_pkg::REG_UPRIGHT_KD:        upr_kd_q <= cfg_data;
					brcc_pkg::REG_SPEED_KP:          spd_kp_q <= cfg_data;
					brcc_pkg::REG_SPEED_KI:          spd_ki_q <= cfg_data;
					brcc_pkg::REG_YAW_DAMPING_GAIN:  yaw_gain_q <= cfg_data;
					brcc_pkg::REG_TURN_COMMAND_GAIN: turn_gain_q <= cfg_data;
					brcc_pkg::REG_LINE_FOLLOW:       lfe_q <= cfg_data[0];
					default:                         lfe_q <= lfe_q;
				endcase
			end
			case (state_q)
				brcc_pkg::S_CMD: begin
					ts_q <= brcc_pkg::TGT_W'(ts_cmd);
					tt_q <= brcc_pkg::TGT_W'(tt_cmd);
				end
				brcc_pkg::S_LT_MUL: begin
					ts_q  <= brcc_pkg::TGT_W'(quo);
					lss_q <= brcc_pkg::TGT_W'(quo);
				end
				brcc_pkg::S_LT_FIN: begin
					tt_q  <= brcc_pkg::TGT_W'(quo);
					lts_q <= brcc_pkg::TGT_W'(quo);
				end
				brcc_pkg::S_FILT_FIN: begin
					filt_q  <= brcc_pkg::FILT_W'(quo);
					integ_q <= brcc_pkg::INTEG_W'(integ_new);
				end
				default: begin
					ts_q <= ts_q;
				end
			endcase
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Captured tick fields and arithmetic datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			left_q    <= s_tdata[15:0];
			right_q   <= s_tdata[31:16];
			pitch_q   <= s_tdata[48:32];
			prate_q   <= s_tdata[64:49];
			yaw_q     <= s_tdata[80:65];
			fwd_q     <= s_tdata[81];
			back_q    <= s_tdata[82];
			lcmd_q    <= s_tdata[83];
			rcmd_q    <= s_tdata[84];
			dist_q    <= s_tdata[100:85];
			pattern_q <= ~s_tdata[105:101];
			clr_q     <= s_tdata[106];
		end
		if (state_q == brcc_pkg::S_LS_MUL || state_q == brcc_pkg::S_LT_MUL
				|| state_q == brcc_pkg::S_FILT_MUL) begin
			neg_q <= div_num[brcc_pkg::NUM_W-1];
		end
		if (state_q == brcc_pkg::S_SPD_M2 || state_q == brcc_pkg::S_TRN_M2
				|| state_q == brcc_pkg::S_UPR_M2) begin
			acc_q <= prod_ext;
		end
		if (state_q == brcc_pkg::S_SPD_FIN) begin
			spd_q <= brcc_pkg::sat16(brcc_pkg::trunc_shr(sum_plain, brcc_pkg::SPEED_SHIFT));
		end
		if (state_q == brcc_pkg::S_TRN_FIN) begin
			trn_q <= brcc_pkg::sat16(brcc_pkg::trunc_shr(sum_plain, brcc_pkg::SPEED_SHIFT));
		end
		if (state_q == brcc_pkg::S_UPR_FIN) begin
			upr_q <= brcc_pkg::sat16(brcc_pkg::trunc_shr(sum_kd, brcc_pkg::UPR_SHIFT));
		end
		if (out_load) begin
			m_tdata_q <= {trn_q, spd_q, upr_q, mot_r, mot_l};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == brcc_pkg::S_CMD))
		else $error("accepted transfer did not start the sequencer");

	a_integ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(19'(integ_q) <= INT_LIM) && (19'(integ_q) >= -INT_LIM))
		else $error("speed integrator outside its clamp");

	a_cmd_speed_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == brcc_pkg::S_CMD && !lfe_q) |=>
		((10'(ts_q) <= SPD_LIM) && (10'(ts_q) >= -SPD_LIM)))
		else $error("commanded target speed outside its limit");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == brcc_pkg::S_IDLE))
		else $error("result load did not present a transfer");

endmodule
